/* sv/sfr_pkg.sv */
// shared constants and types for the fresnel reflectance pipeline
`default_nettype none
package sfr_pkg;

  // unsigned q.30 value, 1.0 = 2^30
  typedef logic [30:0] q30_t;

  localparam q30_t ONE_Q30 = 31'h4000_0000;
  localparam logic [15:0] REFL_ONE = 16'h8000;

  // number of quotient and root bits produced, one per stage
  localparam int unsigned STEPS = 31;

  // control carried alongside the divider and root stages
  typedef struct packed {
    logic gt;     // n1 > n2
    logic tir;    // total internal reflection
    logic szero;  // n1 + n2 == 0
    q30_t c;      // cosine before refraction
  } sfr_ctl_t;

endpackage
`default_nettype wire

/* sv/schlick_fresnel_reflectance_top.sv */
// schlick fresnel reflectance pipeline, top level
//
// usage
//   input channel (in_valid / in_ready) takes one word per cycle while
//   in_ready is high: eye and normal vectors (signed, VEC_FRAC_BITS
//   fraction bits) and the indices n1 and n2 (unsigned q4.12).
//   output channel (out_valid / out_ready) returns one word per input word,
//   in order: reflectance in q1.15 (32768 = 1.0) and the total internal
//   reflection flag.
//   the path from acceptance to out_valid runs through dot product and
//   squaring, the radix-2 divider (sin^2 and r0 share these stages), the
//   bit-serial square root, then the power-of-five chain and final blend.
//   throughput is one word per cycle while the output is not stalled;
//   every stage is a register stage with its own valid bit.
//   when out_valid is high and out_ready low, the whole pipeline holds and
//   in_ready drops; nothing is lost or repeated. in_ready stays high while
//   the output register is empty or being taken.
//   reset (rst_n low, synchronous) clears all valid bits; data registers
//   keep whatever they hold.
`default_nettype none
module schlick_fresnel_reflectance_top
  import sfr_pkg::*;
#(
  parameter int VEC_FRAC_BITS = 14
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output      logic               in_ready,
  input  wire logic signed [15:0] in_eye_x,
  input  wire logic signed [15:0] in_eye_y,
  input  wire logic signed [15:0] in_eye_z,
  input  wire logic signed [15:0] in_normal_x,
  input  wire logic signed [15:0] in_normal_y,
  input  wire logic signed [15:0] in_normal_z,
  input  wire logic        [15:0] in_index_from,
  input  wire logic        [15:0] in_index_into,
  output      logic               out_valid,
  input  wire logic               out_ready,
  output      logic        [15:0] out_reflectance,
  output      logic               out_total_internal
);

  localparam int LSH = (2 * VEC_FRAC_BITS <= 30) ? 30 - 2 * VEC_FRAC_BITS : 0;
  localparam int RSH = (2 * VEC_FRAC_BITS > 30) ? 2 * VEC_FRAC_BITS - 30 : 0;
  localparam int CW  = 32 + LSH;
  localparam int NST = 4 + 32 + 32 + 6;

  logic           en;
  logic [NST-1:0] vld_r;

  // global advance: hold only when the output word is stalled
  assign en        = ~vld_r[NST-1] | out_ready;
  assign in_ready  = en;
  assign out_valid = vld_r[NST-1];

  // valid bits travel with the data
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[NST-2:0], in_valid};
    end
  end

  // stage 1: products and index terms
  logic signed [31:0] p0_r, p1_r, p2_r;
  logic [31:0] n1sq1_r, n2sq1_r;
  logic [15:0] dn1_r;
  logic [16:0] sm1_r;
  logic        gt1_r;

  always_ff @(posedge clk) begin
    if (en) begin
      p0_r    <= 32'(in_eye_x) * 32'(in_normal_x);
      p1_r    <= 32'(in_eye_y) * 32'(in_normal_y);
      p2_r    <= 32'(in_eye_z) * 32'(in_normal_z);
      n1sq1_r <= 32'(in_index_from) * 32'(in_index_from);
      n2sq1_r <= 32'(in_index_into) * 32'(in_index_into);
      dn1_r   <= (in_index_from > in_index_into) ? in_index_from - in_index_into
                                                 : in_index_into - in_index_from;
      sm1_r   <= 17'(in_index_from) + 17'(in_index_into);
      gt1_r   <= in_index_from > in_index_into;
    end
  end

  // stage 2: dot product, rescale and clamp; squares of difference and sum
  logic signed [33:0] dot;
  logic [CW-1:0]      cw;
  q30_t               c_nxt;
  q30_t               c2s_r;
  logic [31:0]        dd2_r, n1sq2_r, n2sq2_r;
  logic [33:0]        ss2_r;
  logic               gt2_r;

  always_comb begin
    dot = 34'(p0_r) + 34'(p1_r) + 34'(p2_r);
    cw  = (CW'(dot[31:0]) << LSH) >> RSH;
    if (dot[33] || dot == '0) begin
      c_nxt = '0;
    end else if (cw > CW'(ONE_Q30)) begin
      c_nxt = ONE_Q30;
    end else begin
      c_nxt = cw[30:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c2s_r   <= c_nxt;
      dd2_r   <= 32'(dn1_r) * 32'(dn1_r);
      ss2_r   <= 34'(sm1_r) * 34'(sm1_r);
      n1sq2_r <= n1sq1_r;
      n2sq2_r <= n2sq1_r;
      gt2_r   <= gt1_r;
    end
  end

  // stage 3: cos^2
  logic [61:0] csq;
  q30_t        c3_r, csq3_r;
  logic [31:0] dd3_r, n1sq3_r, n2sq3_r;
  logic [33:0] ss3_r;
  logic        gt3_r;

  assign csq = 62'(c2s_r) * 62'(c2s_r);

  always_ff @(posedge clk) begin
    if (en) begin
      c3_r    <= c2s_r;
      csq3_r  <= csq[60:30];
      dd3_r   <= dd2_r;
      ss3_r   <= ss2_r;
      n1sq3_r <= n1sq2_r;
      n2sq3_r <= n2sq2_r;
      gt3_r   <= gt2_r;
    end
  end

  // stage 4: numerator n1^2 * (1 - cos^2)
  logic [62:0] num4_r;
  q30_t        c4_r;
  logic [31:0] dd4_r, n2sq4_r;
  logic [33:0] ss4_r;
  logic        gt4_r;

  always_ff @(posedge clk) begin
    if (en) begin
      num4_r  <= 63'(n1sq3_r) * 63'(ONE_Q30 - csq3_r);
      c4_r    <= c3_r;
      dd4_r   <= dd3_r;
      ss4_r   <= ss3_r;
      n2sq4_r <= n2sq3_r;
      gt4_r   <= gt3_r;
    end
  end

  // divider stages: sin^2 = num / n2^2 and r0 = (d^2 << 30) / s^2
  logic [62:0] dv_rem_r [0:STEPS];
  logic [31:0] dv_den_r [0:STEPS];
  q30_t        dv_q_r   [0:STEPS];
  logic [63:0] r0_rem_r [0:STEPS];
  logic [33:0] r0_dvs_r [0:STEPS];
  q30_t        r0_q_r   [0:STEPS];
  sfr_ctl_t    dv_ctl_r [0:STEPS];

  logic [62:0] dv_rem_nxt [0:STEPS-1];
  q30_t        dv_q_nxt   [0:STEPS-1];
  logic [63:0] r0_rem_nxt [0:STEPS-1];
  q30_t        r0_q_nxt   [0:STEPS-1];
  sfr_ctl_t    ctl0_nxt;

  always_comb begin
    ctl0_nxt.gt    = gt4_r;
    ctl0_nxt.tir   = gt4_r && (n2sq4_r == '0 || num4_r > {1'b0, n2sq4_r, 30'b0});
    ctl0_nxt.szero = (ss4_r == '0);
    ctl0_nxt.c     = c4_r;
  end

  // one quotient bit per stage for each divider
  always_comb begin
    logic [62:0] dsh;
    logic [64:0] rsh;
    for (int j = 0; j < STEPS; j++) begin
      dsh = 63'(dv_den_r[j]) << (STEPS - 1 - j);
      rsh = 65'(r0_dvs_r[j]) << (STEPS - 1 - j);
      dv_q_nxt[j] = dv_q_r[j];
      r0_q_nxt[j] = r0_q_r[j];
      if (dv_rem_r[j] >= dsh) begin
        dv_rem_nxt[j] = dv_rem_r[j] - dsh;
        dv_q_nxt[j][STEPS-1-j] = 1'b1;
      end else begin
        dv_rem_nxt[j] = dv_rem_r[j];
      end
      if (65'(r0_rem_r[j]) >= rsh) begin
        r0_rem_nxt[j] = 64'(65'(r0_rem_r[j]) - rsh);
        r0_q_nxt[j][STEPS-1-j] = 1'b1;
      end else begin
        r0_rem_nxt[j] = r0_rem_r[j];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dv_rem_r[0] <= num4_r;
      dv_den_r[0] <= n2sq4_r;
      dv_q_r[0]   <= '0;
      r0_rem_r[0] <= {dd4_r, 32'b0} >> 2;
      r0_dvs_r[0] <= ss4_r;
      r0_q_r[0]   <= '0;
      dv_ctl_r[0] <= ctl0_nxt;
      for (int j = 0; j < STEPS; j++) begin
        dv_rem_r[j+1] <= dv_rem_nxt[j];
        dv_den_r[j+1] <= dv_den_r[j];
        dv_q_r[j+1]   <= dv_q_nxt[j];
        r0_rem_r[j+1] <= r0_rem_nxt[j];
        r0_dvs_r[j+1] <= r0_dvs_r[j];
        r0_q_r[j+1]   <= r0_q_nxt[j];
        dv_ctl_r[j+1] <= dv_ctl_r[j];
      end
    end
  end

  // square root stages: floor sqrt((1 - sin^2) << 30), one root bit per stage
  logic [60:0] sq_rem_r [0:STEPS];
  q30_t        sq_res_r [0:STEPS];
  q30_t        sq_r0_r  [0:STEPS];
  sfr_ctl_t    sq_ctl_r [0:STEPS];

  logic [60:0] sq_rem_nxt [0:STEPS-1];
  q30_t        sq_res_nxt [0:STEPS-1];
  q30_t        omsin;
  q30_t        r0_nxt;

  always_comb begin
    omsin = ONE_Q30 - dv_q_r[STEPS];
    if (dv_ctl_r[STEPS].szero) begin
      r0_nxt = '0;
    end else if (r0_q_r[STEPS] > ONE_Q30) begin
      r0_nxt = ONE_Q30;
    end else begin
      r0_nxt = r0_q_r[STEPS];
    end
  end

  always_comb begin
    logic [62:0] trial;
    for (int j = 0; j < STEPS; j++) begin
      trial = (63'(sq_res_r[j]) << (STEPS - j)) + (63'(1) << (2 * (STEPS - 1 - j)));
      sq_res_nxt[j] = sq_res_r[j];
      if (63'(sq_rem_r[j]) >= trial) begin
        sq_rem_nxt[j] = 61'(63'(sq_rem_r[j]) - trial);
        sq_res_nxt[j][STEPS-1-j] = 1'b1;
      end else begin
        sq_rem_nxt[j] = sq_rem_r[j];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sq_rem_r[0] <= {omsin, 30'b0};
      sq_res_r[0] <= '0;
      sq_r0_r[0]  <= r0_nxt;
      sq_ctl_r[0] <= dv_ctl_r[STEPS];
      for (int j = 0; j < STEPS; j++) begin
        sq_rem_r[j+1] <= sq_rem_nxt[j];
        sq_res_r[j+1] <= sq_res_nxt[j];
        sq_r0_r[j+1]  <= sq_r0_r[j];
        sq_ctl_r[j+1] <= sq_ctl_r[j];
      end
    end
  end

  // power chain: x = 1 - cos, then x^2, x^4, x^5
  q30_t        cfin;
  q30_t        x1_r, r01_r;
  logic        tir1_r;
  q30_t        x2_r, xa2_r, r02_r;
  logic        tir2_r;
  q30_t        x4_r, xa3_r, r03_r;
  logic        tir3_r;
  q30_t        x5_r, r04_r;
  logic        tir4_r;
  q30_t        t5_r, r05_r;
  logic        tir5_r;
  logic [61:0] m2, m3, m4, m5;

  always_comb begin
    if (!sq_ctl_r[STEPS].gt) begin
      cfin = sq_ctl_r[STEPS].c;
    end else if (sq_res_r[STEPS] > ONE_Q30) begin
      cfin = ONE_Q30;
    end else begin
      cfin = sq_res_r[STEPS];
    end
  end

  assign m2 = 62'(x1_r) * 62'(x1_r);
  assign m3 = 62'(x2_r) * 62'(x2_r);
  assign m4 = 62'(x4_r) * 62'(xa3_r);
  assign m5 = 62'(ONE_Q30 - r04_r) * 62'(x5_r);

  always_ff @(posedge clk) begin
    if (en) begin
      x1_r   <= ONE_Q30 - cfin;
      r01_r  <= sq_r0_r[STEPS];
      tir1_r <= sq_ctl_r[STEPS].tir;
      x2_r   <= m2[60:30];
      xa2_r  <= x1_r;
      r02_r  <= r01_r;
      tir2_r <= tir1_r;
      x4_r   <= m3[60:30];
      xa3_r  <= xa2_r;
      r03_r  <= r02_r;
      tir3_r <= tir2_r;
      x5_r   <= m4[60:30];
      r04_r  <= r03_r;
      tir4_r <= tir3_r;
      t5_r   <= m5[60:30];
      r05_r  <= r04_r;
      tir5_r <= tir4_r;
    end
  end

  // blend, saturate, round to q1.15 into the output register
  logic [31:0] res;
  logic [31:0] rnd;
  logic [15:0] refl_nxt;

  always_comb begin
    res = 32'(r05_r) + 32'(t5_r);
    if (res > 32'(ONE_Q30)) begin
      res = 32'(ONE_Q30);
    end
    rnd      = (res + 32'h4000) >> 15;
    refl_nxt = tir5_r ? REFL_ONE : rnd[15:0];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_reflectance    <= refl_nxt;
      out_total_internal <= tir5_r;
    end
  end

endmodule
`default_nettype wire

/* sv/sfr_checker.sv */
// port-level checks for the fresnel reflectance pipeline, bound to the top
`default_nettype none
module sfr_checker
  import sfr_pkg::*;
(
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_ready,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [15:0] out_reflectance,
  input wire logic        out_total_internal
);

  // a stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_reflectance)
      && $stable(out_total_internal))
    else $error("stalled result changed");

  // reflectance never exceeds 1.0
  a_refl_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_reflectance <= REFL_ONE)
    else $error("reflectance above 1.0");

  // total internal reflection always reports full reflectance
  a_tir_one: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_total_internal |-> out_reflectance == REFL_ONE)
    else $error("tir without full reflectance");

  // empty output register never blocks the input
  a_no_block: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input blocked with empty output");

  // nothing comes out right after reset
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result shown after reset");

endmodule

bind schlick_fresnel_reflectance_top sfr_checker u_sfr_checker (
  .clk                (clk),
  .rst_n              (rst_n),
  .in_ready           (in_ready),
  .out_valid          (out_valid),
  .out_ready          (out_ready),
  .out_reflectance    (out_reflectance),
  .out_total_internal (out_total_internal)
);
`default_nettype wire

/* bench/schlick_fresnel_reflectance_top_test.sv */
// testbench for the schlick fresnel reflectance pipeline
`timescale 1ns / 1ps
`default_nettype none

// expected reflectance words, in input order
class reflectance_board;
  logic [15:0] want_refl[$];
  logic        want_tir[$];
  int          errors;

  // integer square root, floored
  static function automatic logic [63:0] root_floor(logic [63:0] v);
    logic [63:0] res;
    logic [63:0] b;
    res = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v = v - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  static function automatic logic [63:0] mulq(logic [63:0] a, logic [63:0] b);
    logic [127:0] p;
    p = a * b;
    return p[93:30];
  endfunction

  // work out one reflectance from an accepted input word
  function void note_input(logic signed [15:0] ex, ey, ez, nx, ny, nz,
                           logic [15:0] n1w, n2w);
    logic signed [63:0] dot;
    logic [63:0] one, c, r0, n1, n2, c2, num, den, s2, d, s, x, x2, x4, x5, res;
    logic [127:0] big;
    one = 64'd1 << 30;
    dot = 64'(ex) * 64'(nx) + 64'(ey) * 64'(ny) + 64'(ez) * 64'(nz);
    n1 = n1w;
    n2 = n2w;
    c = 0;
    r0 = 0;
    if (dot > 0) begin
      c = 64'(dot) << 2;
      if (c > one) c = one;
    end
    if (n1 > n2) begin
      c2 = mulq(c, c);
      num = n1 * n1 * (one - c2);
      den = n2 * n2;
      if (den == 0 || num > (den << 30)) begin
        want_refl.insert(want_refl.size(), 16'h8000);
        want_tir.insert(want_tir.size(), 1'b1);
        return;
      end
      s2 = num / den;
      c = root_floor((one - s2) << 30);
      if (c > one) c = one;
    end
    d = (n1 > n2) ? n1 - n2 : n2 - n1;
    s = n1 + n2;
    if (s != 0) begin
      big = (128'(d * d) << 30) / 128'(s * s);
      r0 = big[63:0];
    end
    if (r0 > one) r0 = one;
    x = one - c;
    x2 = mulq(x, x);
    x4 = mulq(x2, x2);
    x5 = mulq(x4, x);
    res = r0 + mulq(one - r0, x5);
    if (res > one) res = one;
    res = (res + (64'd1 << 14)) >> 15;
    want_refl.insert(want_refl.size(), res[15:0]);
    want_tir.insert(want_tir.size(), 1'b0);
  endfunction

  function void report(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s: got %0d want %0d", what, got, want);
    errors++;
  endfunction

  // compare one result word against the oldest expectation
  function void check_result(logic [15:0] refl, logic tir);
    logic [15:0] wr;
    logic        wt;
    if (want_refl.size() == 0) begin
      report("unexpected word", refl, 0);
      return;
    end
    wr = want_refl.pop_front();
    wt = want_tir.pop_front();
    if (refl !== wr) report("reflectance", refl, wr);
    if (tir !== wt) report("total_internal", tir, wt);
  endfunction
endclass

module schlick_fresnel_reflectance_top_test;

  localparam int LATENCY = 74;
  localparam int WATCH_LIMIT = 20000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic signed [15:0] in_eye_x = '0, in_eye_y = '0, in_eye_z = '0;
  logic signed [15:0] in_normal_x = '0, in_normal_y = '0, in_normal_z = '0;
  logic [15:0] in_index_from = '0, in_index_into = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [15:0] out_reflectance;
  logic out_total_internal;

  reflectance_board board = new();
  int send_idle_pct = 0;
  int stall_pct = 0;
  bit hold_off = 1'b0;
  int quiet_cycles = 0;

  always #5 clk = ~clk;

  schlick_fresnel_reflectance_top dut (
    .clk, .rst_n, .in_valid, .in_ready,
    .in_eye_x, .in_eye_y, .in_eye_z,
    .in_normal_x, .in_normal_y, .in_normal_z,
    .in_index_from, .in_index_into,
    .out_valid, .out_ready, .out_reflectance, .out_total_internal
  );

  // accepted words: note inputs, check results, watchdog
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready)
        board.note_input(in_eye_x, in_eye_y, in_eye_z, in_normal_x, in_normal_y,
                         in_normal_z, in_index_from, in_index_into);
      if (out_valid && out_ready)
        board.check_result(out_reflectance, out_total_internal);
      if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCH_LIMIT) begin
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  // receiver readiness
  always @(posedge clk) begin
    if (!rst_n || hold_off) out_ready <= 1'b0;
    else out_ready <= ($urandom_range(99) >= stall_pct);
  end

  // offer one word, idling first at random
  task automatic send_word(logic signed [15:0] ex, ey, ez, nx, ny, nz,
                           logic [15:0] n1, n2);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_eye_x <= ex; in_eye_y <= ey; in_eye_z <= ez;
    in_normal_x <= nx; in_normal_y <= ny; in_normal_z <= nz;
    in_index_from <= n1; in_index_into <= n2;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // random index, mostly realistic, sometimes full range
  function automatic logic [15:0] pick_index();
    case ($urandom_range(3))
      0: return 16'($urandom_range(65535));
      1: return 16'($urandom_range(4096, 12288));
      2: return 16'($urandom_range(4096, 6200));
      default: return 16'($urandom_range(0, 8192));
    endcase
  endfunction

  // random input word: vector components within +/-9500 or raw bits
  task automatic send_random();
    logic signed [15:0] v[6];
    int k;
    if ($urandom_range(3) == 0) begin
      for (k = 0; k < 6; k++) v[k] = 16'($urandom);
    end else begin
      for (k = 0; k < 6; k++) v[k] = 16'($signed($urandom_range(0, 19000)) - 9500);
    end
    send_word(v[0], v[1], v[2], v[3], v[4], v[5], pick_index(), pick_index());
  endtask

  task automatic run_phase(int idle, int stall, int count);
    send_idle_pct = idle;
    stall_pct = stall;
    repeat (count) send_random();
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    // directed: extremes, negative and saturated cosine, tir, zero indices
    send_word(16'sh4000, 0, 0, 16'sh4000, 0, 0, 16'd4096, 16'd6144);
    send_word(16'sh4000, 0, 0, -16'sh4000, 0, 0, 16'd4096, 16'd6144);
    send_word(16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff,
              16'd6144, 16'd4096);
    send_word(-16'sh8000, -16'sh8000, -16'sh8000, -16'sh8000, -16'sh8000,
              -16'sh8000, 16'hffff, 16'hffff);
    send_word(16'sh2000, 0, 0, 16'sh4000, 0, 0, 16'd6144, 16'd4096);
    send_word(16'sh0400, 0, 0, 16'sh4000, 0, 0, 16'd6144, 16'd4096);
    send_word(16'sh2d41, 16'sh2d41, 0, 0, 16'sh4000, 0, 16'd8192, 16'd4096);
    send_word(16'sh4000, 0, 0, 16'sh4000, 0, 0, 16'd4096, 16'd0);
    send_word(0, 0, 0, 0, 0, 0, 16'd0, 16'd0);
    send_word(0, 0, 0, 0, 0, 0, 16'd4096, 16'd4096);
    send_word(16'sh4000, 0, 0, 16'sh4000, 0, 0, 16'hffff, 16'd4096);
    send_word(16'sh4000, 0, 0, 16'sh4000, 0, 0, 16'd4096, 16'hffff);
    send_word(16'sh5555, 16'shaaaa, 16'sh5555, 16'shaaaa, 16'sh5555, 16'shaaaa,
              16'haaaa, 16'h5555);
    send_word(16'shaaaa, 16'sh5555, 16'shaaaa, 16'sh5555, 16'shaaaa, 16'sh5555,
              16'h5555, 16'haaaa);
    send_word(16'sh3fff, 0, 0, 16'sh4000, 0, 0, 16'd5461, 16'd4096);
    run_phase(0, 0, 400);
    run_phase(71, 0, 300);
    run_phase(0, 71, 300);
    run_phase(35, 35, 300);
    // long hold-off on the receiver while words keep coming
    fork
      begin
        hold_off = 1'b1;
        repeat (300) @(posedge clk);
        hold_off = 1'b0;
      end
      run_phase(0, 0, 300);
    join
    in_valid <= 1'b0;
    while (board.want_refl.size() != 0) @(posedge clk);
    repeat (LATENCY + 10) @(posedge clk);
    if (board.errors == 0 && board.want_refl.size() == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end
endmodule

`default_nettype wire
